// ===== rtl/core/gbp_pkg.sv =====
// Shared types and constants for the generational buffer pool.
// No dependencies; every other file but gbp_ram takes names from here by scope.
package gbp_pkg;

  localparam int Buffers   = 64;
  localparam int LastState = 3;
  localparam int SlotW     = $clog2(Buffers);
  localparam int CntW      = 7;
  localparam int GenW      = 32;
  localparam int StW       = 4;
  localparam int EntryW    = StW + GenW;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 32;

  localparam logic [GenW-1:0] GenReset   = 32'h0001_0000;
  localparam logic [CntW-1:0] CountReset = 7'd64;

  localparam logic [CfgIdxW-1:0] CfgBufferCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgGenerationBase = 2'd1;

  localparam logic [2:0] ReqAcquire    = 3'd0;
  localparam logic [2:0] ReqTransition = 3'd1;
  localparam logic [2:0] ReqRelease    = 3'd2;
  localparam logic [2:0] ReqLookup     = 3'd3;
  localparam logic [2:0] ReqRevoke     = 3'd4;
  localparam logic [2:0] ReqRestart    = 3'd5;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACQ_RD,
    ST_ACQ_CHK,
    ST_HND_RD,
    ST_HND_CHK,
    ST_REV_RD,
    ST_REV_WR
  } pool_state_t;

  function automatic logic [CntW-1:0] clamp_count(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    r = v;
    if (v == '0) r = CntW'(1);
    else if (v > CntW'(Buffers)) r = CntW'(Buffers);
    return r;
  endfunction

  function automatic logic [GenW-1:0] bump_gen(input logic [GenW-1:0] g);
    logic [GenW-1:0] n;
    n = g + GenW'(1);
    return (n == '0) ? GenW'(1) : n;
  endfunction

  function automatic logic state_ok(input logic [StW-1:0] s);
    return (s != '0) && (s <= StW'(LastState));
  endfunction

endpackage

// ===== rtl/core/gbp_if.sv =====
// Handshake channels of the buffer pool: requests, responses, config writes.
// Depends on gbp_pkg for widths.
interface gbp_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [63:0] handle;
  logic [3:0]  match_state;
  logic [3:0]  set_state;
  modport source (output valid, req_type, handle, match_state, set_state, input ready);
  modport sink (input valid, req_type, handle, match_state, set_state, output ready);
endinterface

interface gbp_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [63:0] handle_out;
  logic [5:0]  slot_index;
  logic [6:0]  free_count;
  modport source (output valid, status, handle_out, slot_index, free_count, input ready);
  modport sink (input valid, status, handle_out, slot_index, free_count, output ready);
endinterface

interface gbp_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gbp_pkg::CfgIdxW-1:0]   index;
  logic [gbp_pkg::CfgDataW-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/generational_buffer_pool.sv =====
// Top level of the generational buffer pool: sequencer around one slot RAM.
// Depends on gbp_pkg, gbp_if and gbp_ram.
//
//   channel  dir  contents
//   req      in   req_type, handle, match_state, set_state
//   rsp      out  status, handle_out, slot_index, free_count
//   cfg      in   index, data (pool size, generation base)
//
// Transition, release and lookup pass a RAM read, then a check and write, then the response;
// acquire reads and checks each probed slot in turn. Revoke reads and rewrites each live
// slot in turn, restart refills every slot. The single RAM port pair holds {state, generation}.
// After reset a fill pass writes every slot before the first request is taken.
// The response register holds a result until taken; a new request enters meanwhile.
module generational_buffer_pool (
  input logic clk,
  input logic rst,
  gbp_req_if.sink   req,
  gbp_rsp_if.source rsp,
  gbp_cfg_if.sink   cfg
);
  localparam int SlotW  = gbp_pkg::SlotW;
  localparam int CntW   = gbp_pkg::CntW;
  localparam int GenW   = gbp_pkg::GenW;
  localparam int StW    = gbp_pkg::StW;
  localparam int EntryW = gbp_pkg::EntryW;

  gbp_pkg::pool_state_t state, state_next;

  logic [CntW-1:0]  pool_size;
  logic [GenW-1:0]  generation_base;
  logic [CntW-1:0]  live, live_next;
  logic [SlotW-1:0] next_slot, next_slot_next;
  logic             revoked, revoked_next;
  logic [CntW-1:0]  free_total, free_total_next;
  logic [CntW-1:0]  cnt, cnt_next;
  logic [SlotW-1:0] probe, probe_next;
  logic [GenW-1:0]  fill_gen, fill_gen_next;
  logic             init_resp, init_resp_next;
  logic [2:0]       rtype, rtype_next;
  logic [GenW-1:0]  hgen, hgen_next;
  logic [StW-1:0]   exp_st, exp_st_next;
  logic [StW-1:0]   new_st, new_st_next;

  logic             res_pend, res_pend_next;
  logic             res_status, res_status_next;
  logic [63:0]      res_hout, res_hout_next;
  logic [SlotW-1:0] res_sidx, res_sidx_next;

  logic              we;
  logic [SlotW-1:0]  waddr, raddr;
  logic [EntryW-1:0] wdata, rdata;
  logic [StW-1:0]    rd_st;
  logic [GenW-1:0]   rd_gen;
  logic [31:0]       low;
  logic              hnd_ok;
  logic              rsp_free;
  logic [SlotW-1:0]  probe_inc;

  gbp_ram #(.WIDTH(EntryW), .DEPTH(gbp_pkg::Buffers)) u_slots (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign rd_st     = rdata[EntryW-1:GenW];
  assign rd_gen    = rdata[GenW-1:0];
  assign low       = req.handle[31:0];
  assign rsp_free  = !rsp.valid || rsp.ready;
  assign probe_inc = ({1'b0, probe} + (SlotW+1)'(1) == (SlotW+1)'(live)) ? '0
                     : probe + SlotW'(1);
  assign hnd_ok    = (rd_gen == hgen) && (rd_st != '0) && (rd_st == exp_st);
  assign req.ready = (state == gbp_pkg::ST_IDLE) && !res_pend;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size       <= gbp_pkg::CountReset;
      generation_base <= gbp_pkg::GenReset;
    end else if (cfg.valid) begin
      case (cfg.index)
        gbp_pkg::CfgBufferCount:    pool_size <= cfg.data[CntW-1:0];
        gbp_pkg::CfgGenerationBase: generation_base <= cfg.data[GenW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_next      = state;
    live_next       = live;
    next_slot_next  = next_slot;
    revoked_next    = revoked;
    free_total_next = free_total;
    cnt_next        = cnt;
    probe_next      = probe;
    fill_gen_next   = fill_gen;
    init_resp_next  = init_resp;
    rtype_next      = rtype;
    hgen_next       = hgen;
    exp_st_next     = exp_st;
    new_st_next     = new_st;
    res_pend_next   = res_pend;
    res_status_next = res_status;
    res_hout_next   = res_hout;
    res_sidx_next   = res_sidx;
    we              = 1'b0;
    waddr           = probe;
    wdata           = {rd_st, rd_gen};
    raddr           = probe;

    // move a finished result into the response register
    if (res_pend && rsp_free) res_pend_next = 1'b0;

    case (state)
      gbp_pkg::ST_INIT: begin
        we    = 1'b1;
        waddr = cnt[SlotW-1:0];
        wdata = {StW'(0), fill_gen};
        cnt_next = cnt + CntW'(1);
        if (cnt == CntW'(gbp_pkg::Buffers - 1)) begin
          state_next = gbp_pkg::ST_IDLE;
          if (init_resp) begin
            res_pend_next   = 1'b1;
            res_status_next = 1'b0;
          end
        end
      end
      gbp_pkg::ST_IDLE: begin
        if (req.valid && req.ready) begin
          rtype_next      = req.req_type;
          hgen_next       = req.handle[63:32];
          exp_st_next     = req.match_state;
          new_st_next     = req.set_state;
          res_status_next = 1'b1;
          res_hout_next   = '0;
          res_sidx_next   = '0;
          case (req.req_type)
            gbp_pkg::ReqAcquire: begin
              if (revoked || !gbp_pkg::state_ok(req.set_state) || free_total == '0) begin
                res_pend_next = 1'b1;
              end else begin
                probe_next = next_slot;
                state_next = gbp_pkg::ST_ACQ_RD;
              end
            end
            gbp_pkg::ReqTransition, gbp_pkg::ReqRelease, gbp_pkg::ReqLookup: begin
              if (low == '0 || low > 32'(live) || req.handle[63:32] == '0) begin
                res_pend_next = 1'b1;
              end else begin
                probe_next = SlotW'(low - 32'd1);
                state_next = gbp_pkg::ST_HND_RD;
              end
            end
            gbp_pkg::ReqRevoke: begin
              if (revoked) begin
                res_pend_next = 1'b1;
              end else begin
                cnt_next   = '0;
                state_next = gbp_pkg::ST_REV_RD;
              end
            end
            gbp_pkg::ReqRestart: begin
              fill_gen_next   = (generation_base == '0) ? GenW'(1) : generation_base;
              live_next       = gbp_pkg::clamp_count(pool_size);
              free_total_next = gbp_pkg::clamp_count(pool_size);
              next_slot_next  = '0;
              revoked_next    = 1'b0;
              cnt_next        = '0;
              init_resp_next  = 1'b1;
              state_next      = gbp_pkg::ST_INIT;
            end
            default: res_pend_next = 1'b1;
          endcase
        end
      end
      gbp_pkg::ST_ACQ_RD: state_next = gbp_pkg::ST_ACQ_CHK;
      gbp_pkg::ST_ACQ_CHK: begin
        if (rd_st == '0) begin
          we              = 1'b1;
          wdata           = {new_st, rd_gen};
          next_slot_next  = probe_inc;
          free_total_next = free_total - CntW'(1);
          res_status_next = 1'b0;
          res_hout_next   = {rd_gen, 32'(probe) + 32'd1};
          res_pend_next   = 1'b1;
          state_next      = gbp_pkg::ST_IDLE;
        end else begin
          // a free slot exists, so the scan always ends
          probe_next = probe_inc;
          state_next = gbp_pkg::ST_ACQ_RD;
        end
      end
      gbp_pkg::ST_HND_RD: state_next = gbp_pkg::ST_HND_CHK;
      gbp_pkg::ST_HND_CHK: begin
        case (rtype)
          gbp_pkg::ReqTransition: begin
            if (hnd_ok && !revoked && gbp_pkg::state_ok(new_st)) begin
              we              = 1'b1;
              wdata           = {new_st, rd_gen};
              res_status_next = 1'b0;
            end
          end
          gbp_pkg::ReqRelease: begin
            if (hnd_ok) begin
              we              = 1'b1;
              wdata           = {StW'(0), gbp_pkg::bump_gen(rd_gen)};
              if (next_slot > probe) next_slot_next = probe;
              free_total_next = free_total + CntW'(1);
              res_status_next = 1'b0;
            end
          end
          default: begin
            if (hnd_ok && !revoked) begin
              res_sidx_next   = probe;
              res_status_next = 1'b0;
            end
          end
        endcase
        res_pend_next = 1'b1;
        state_next    = gbp_pkg::ST_IDLE;
      end
      gbp_pkg::ST_REV_RD: begin
        raddr      = cnt[SlotW-1:0];
        state_next = gbp_pkg::ST_REV_WR;
      end
      gbp_pkg::ST_REV_WR: begin
        we       = 1'b1;
        waddr    = cnt[SlotW-1:0];
        wdata    = {StW'(0), gbp_pkg::bump_gen(rd_gen)};
        cnt_next = cnt + CntW'(1);
        if (cnt + CntW'(1) == live) begin
          free_total_next = live;
          revoked_next    = 1'b1;
          res_status_next = 1'b0;
          res_pend_next   = 1'b1;
          state_next      = gbp_pkg::ST_IDLE;
        end else begin
          state_next = gbp_pkg::ST_REV_RD;
        end
      end
      default: state_next = gbp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= gbp_pkg::ST_INIT;
      live       <= gbp_pkg::clamp_count(gbp_pkg::CountReset);
      free_total <= gbp_pkg::clamp_count(gbp_pkg::CountReset);
      next_slot  <= '0;
      revoked    <= 1'b0;
      cnt        <= '0;
      fill_gen   <= gbp_pkg::GenReset;
      init_resp  <= 1'b0;
      res_pend   <= 1'b0;
      rsp.valid  <= 1'b0;
    end else begin
      state      <= state_next;
      live       <= live_next;
      free_total <= free_total_next;
      next_slot  <= next_slot_next;
      revoked    <= revoked_next;
      cnt        <= cnt_next;
      fill_gen   <= fill_gen_next;
      init_resp  <= init_resp_next;
      res_pend   <= res_pend_next;
      if (res_pend && rsp_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    probe      <= probe_next;
    rtype      <= rtype_next;
    hgen       <= hgen_next;
    exp_st     <= exp_st_next;
    new_st     <= new_st_next;
    res_status <= res_status_next;
    res_hout   <= res_hout_next;
    res_sidx   <= res_sidx_next;
    if (res_pend && rsp_free) begin
      rsp.status     <= res_status;
      rsp.handle_out <= res_hout;
      rsp.slot_index <= res_sidx;
      rsp.free_count <= revoked ? '0 : free_total;
    end
  end

`ifndef SYNTH
  a_free_le_live: assert property (@(posedge clk) disable iff (rst)
    free_total <= live) else $error("free count exceeds pool size");
  a_next_in_pool: assert property (@(posedge clk) disable iff (rst)
    (state != gbp_pkg::ST_INIT) |-> ({1'b0, next_slot} < (SlotW+1)'(live)))
    else $error("next slot outside pool");
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready) else $error("second request taken");
`endif
endmodule

// ===== rtl/core/gbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for generational_buffer_pool: directed table, then random traffic.
// Depends on gbp_pkg, gbp_if and the pool RTL; the pool is predicted in-bench per transfer.
`timescale 1ns / 100ps

module tb_top;

  localparam int CycleLimit = 1500000;
  localparam int SettleCycles = 80;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] handle;
    logic [3:0]  exp_st;
    logic [3:0]  new_st;
  } pool_req_t;

  typedef struct packed {
    logic        status;
    logic [63:0] handle_out;
    logic [5:0]  slot_index;
    logic [6:0]  free_count;
  } pool_rsp_t;

  typedef struct packed {
    pool_req_t req;
    logic      typed;
    pool_rsp_t rsp;
  } dir_row_t;

  logic clk;
  logic rst;

  gbp_req_if req_ch ();
  gbp_rsp_if rsp_ch ();
  gbp_cfg_if cfg_ch ();

  generational_buffer_pool u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch.sink),
    .rsp (rsp_ch.source),
    .cfg (cfg_ch.sink)
  );

  // Pool shadow
  logic [3:0]  sh_state [gbp_pkg::Buffers];
  logic [31:0] sh_gen [gbp_pkg::Buffers];
  logic [5:0]  sh_next;
  logic        sh_revoked;
  int unsigned sh_free;
  int unsigned sh_live;
  logic [6:0]  sh_cfg_count;
  logic [31:0] sh_cfg_gen;

  pool_rsp_t pending_rsp [$];
  int        mismatches;
  int        send_idle_pct;
  int        recv_idle_pct;
  longint    cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned clip_count(logic [6:0] v);
    if (v == '0) return 1;
    if (v > 7'(gbp_pkg::Buffers)) return gbp_pkg::Buffers;
    return int'(v);
  endfunction

  function automatic logic [31:0] next_gen(logic [31:0] g);
    logic [31:0] n;
    n = g + 32'd1;
    return (n == '0) ? 32'd1 : n;
  endfunction

  function automatic logic good_state(logic [3:0] s);
    return (s != '0) && (s <= 4'(gbp_pkg::LastState));
  endfunction

  function automatic void pool_rebuild(logic [31:0] g);
    for (int i = 0; i < gbp_pkg::Buffers; i++) begin
      sh_state[i] = '0;
      sh_gen[i] = g;
    end
    sh_live = clip_count(sh_cfg_count);
    sh_next = '0;
    sh_revoked = 1'b0;
    sh_free = sh_live;
  endfunction

  // Returns slot+1 of a live slot named by the handle, 0 when the handle is stale or bad.
  function automatic int unsigned handle_slot(logic [63:0] h);
    logic [31:0] lo;
    logic [31:0] g;
    lo = h[31:0];
    g = h[63:32];
    if (lo == 0 || lo > sh_live || g == 0) return 0;
    if (sh_gen[lo-1] != g || sh_state[lo-1] == 0) return 0;
    return lo;
  endfunction

  function automatic pool_rsp_t pool_predict(pool_req_t r);
    pool_rsp_t o;
    int unsigned hs;
    int unsigned s;
    int unsigned start;
    o = '0;
    o.status = 1'b1;
    hs = handle_slot(r.handle);
    case (r.kind)
      gbp_pkg::ReqAcquire: begin
        if (!sh_revoked && good_state(r.new_st)) begin
          start = sh_next % sh_live;
          for (int i = 0; i < sh_live; i++) begin
            s = (start + i) % sh_live;
            if (sh_state[s] == 0 && o.status) begin
              sh_state[s] = r.new_st;
              sh_next = 6'((s + 1) % sh_live);
              sh_free--;
              o.handle_out = {sh_gen[s], 32'(s + 1)};
              o.status = 1'b0;
            end
          end
        end
      end
      gbp_pkg::ReqTransition: begin
        if (hs != 0 && !sh_revoked && sh_state[hs-1] == r.exp_st && good_state(r.new_st)) begin
          sh_state[hs-1] = r.new_st;
          o.status = 1'b0;
        end
      end
      gbp_pkg::ReqRelease: begin
        if (hs != 0 && sh_state[hs-1] == r.exp_st) begin
          sh_state[hs-1] = '0;
          sh_gen[hs-1] = next_gen(sh_gen[hs-1]);
          if (sh_next > hs - 1) sh_next = 6'(hs - 1);
          sh_free++;
          o.status = 1'b0;
        end
      end
      gbp_pkg::ReqLookup: begin
        if (hs != 0 && !sh_revoked && sh_state[hs-1] == r.exp_st) begin
          o.slot_index = 6'(hs - 1);
          o.status = 1'b0;
        end
      end
      gbp_pkg::ReqRevoke: begin
        if (!sh_revoked) begin
          sh_revoked = 1'b1;
          for (int i = 0; i < sh_live; i++) begin
            sh_state[i] = '0;
            sh_gen[i] = next_gen(sh_gen[i]);
          end
          sh_free = sh_live;
          o.status = 1'b0;
        end
      end
      gbp_pkg::ReqRestart: begin
        pool_rebuild((sh_cfg_gen == 0) ? 32'd1 : sh_cfg_gen);
        o.status = 1'b0;
      end
      default: ;
    endcase
    o.free_count = sh_revoked ? 7'd0 : ((sh_free > 127) ? 7'd127 : 7'(sh_free));
    return o;
  endfunction

  // Send one request; predict on the transfer edge.
  task automatic send_req(pool_req_t r, logic typed, pool_rsp_t typed_rsp);
    pool_rsp_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= r.kind;
    req_ch.handle <= r.handle;
    req_ch.match_state <= r.exp_st;
    req_ch.set_state <= r.new_st;
    do @(posedge clk); while (!req_ch.ready);
    p = pool_predict(r);
    pending_rsp.push_back(typed ? typed_rsp : p);
  endtask

  // Leaves valid high; the caller drops it after the last write.
  task automatic cfg_write(logic [gbp_pkg::CfgIdxW-1:0] idx, logic [31:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == gbp_pkg::CfgBufferCount) sh_cfg_count = data[6:0];
    else if (idx == gbp_pkg::CfgGenerationBase) sh_cfg_gen = data;
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic pool_req_t random_req();
    pool_req_t r;
    int unsigned pick;
    int unsigned live [$];
    int unsigned s;
    r.kind = 3'($urandom_range(5));
    r.handle = {$urandom(), $urandom()};
    r.exp_st = 4'($urandom_range(15));
    r.new_st = ($urandom_range(99) < 85) ? 4'($urandom_range(gbp_pkg::LastState, 1))
                                          : 4'($urandom_range(15));
    pick = $urandom_range(999);
    if (pick < 300) r.kind = gbp_pkg::ReqAcquire;
    else if (pick < 500) r.kind = gbp_pkg::ReqTransition;
    else if (pick < 750) r.kind = gbp_pkg::ReqRelease;
    else if (pick < 950) r.kind = gbp_pkg::ReqLookup;
    else if (pick < 970) r.kind = gbp_pkg::ReqRevoke;
    else if (pick < 980) r.kind = gbp_pkg::ReqRestart;
    else r.kind = 3'($urandom_range(7, 6));
    if (r.kind inside {gbp_pkg::ReqTransition, gbp_pkg::ReqRelease, gbp_pkg::ReqLookup}) begin
      for (int i = 0; i < sh_live; i++) if (sh_state[i] != 0) live.push_back(i);
      pick = $urandom_range(99);
      if (live.size() != 0 && pick < 80) begin
        s = live[$urandom_range(live.size() - 1)];
        r.handle = {sh_gen[s], 32'(s + 1)};
        if ($urandom_range(99) < 85) r.exp_st = sh_state[s];
      end else if (pick < 90) begin
        // stale generation or free slot of the right shape
        s = $urandom_range(sh_live - 1);
        r.handle = {sh_gen[s] + 32'($urandom_range(1)), 32'(s + 1)};
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    pool_rsp_t got;
    pool_rsp_t want;
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
    rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    if (rsp_ch.valid && rsp_ch.ready) begin
      got = {rsp_ch.status, rsp_ch.handle_out, rsp_ch.slot_index, rsp_ch.free_count};
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %h", got);
      end else begin
        want = pending_rsp.pop_front();
        if (got.status !== want.status || got.handle_out !== want.handle_out ||
            got.slot_index !== want.slot_index || got.free_count !== want.free_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp st=%0d h=%h slot=%0d free=%0d",
                     want.status, want.handle_out, want.slot_index, want.free_count,
                     " got st=%0d h=%h slot=%0d free=%0d",
                     got.status, got.handle_out, got.slot_index, got.free_count);
        end
      end
    end
  end

  function automatic dir_row_t row(logic [2:0] k, logic [63:0] h, logic [3:0] es,
                                   logic [3:0] ns, logic t, logic st, logic [63:0] ho,
                                   logic [5:0] si, logic [6:0] fc);
    dir_row_t d;
    d.req = '{kind: k, handle: h, exp_st: es, new_st: ns};
    d.typed = t;
    d.rsp = '{status: st, handle_out: ho, slot_index: si, free_count: fc};
    return d;
  endfunction

  initial begin
    dir_row_t    table_rows [$];
    logic [6:0]  ph_count [7];
    logic [31:0] ph_gen [7];
    int          sent;
    pool_req_t   r;

    rst = 1'b1;
    cycles = 0;
    mismatches = 0;
    send_idle_pct = 8;
    recv_idle_pct = 87;
    req_ch.valid = 1'b0;
    req_ch.req_type = gbp_pkg::ReqLookup;
    req_ch.handle = '0;
    req_ch.match_state = '0;
    req_ch.set_state = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = gbp_pkg::CfgBufferCount;
    cfg_ch.data = '0;
    sh_cfg_count = gbp_pkg::CountReset;
    sh_cfg_gen = gbp_pkg::GenReset;
    pool_rebuild(gbp_pkg::GenReset);

    table_rows.push_back(row(gbp_pkg::ReqLookup, 64'd0, 4'd0, 4'd1,
                             1'b1, 1'b1, '0, '0, 7'd64));
    table_rows.push_back(row(gbp_pkg::ReqAcquire, 64'd0, 4'd0, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd64));
    table_rows.push_back(row(gbp_pkg::ReqAcquire, 64'd0, 4'd0, 4'd4,
                             1'b1, 1'b1, '0, '0, 7'd64));
    table_rows.push_back(row(gbp_pkg::ReqAcquire, 64'd0, 4'd0, 4'd3,
                             1'b1, 1'b0, {gbp_pkg::GenReset, 32'd1}, '0, 7'd63));
    table_rows.push_back(row(gbp_pkg::ReqAcquire, '1, 4'hF, 4'd1,
                             1'b1, 1'b0, {gbp_pkg::GenReset, 32'd2}, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqLookup, {gbp_pkg::GenReset, 32'd1}, 4'd3, 4'd0,
                             1'b1, 1'b0, '0, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqLookup, {gbp_pkg::GenReset, 32'd2}, 4'd1, 4'd0,
                             1'b0, 1'b0, '0, '0, '0));
    table_rows.push_back(row(gbp_pkg::ReqLookup, {gbp_pkg::GenReset, 32'd1}, 4'd1, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqLookup, {32'h0001_0001, 32'd1}, 4'd3, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqLookup, {gbp_pkg::GenReset, 32'd65}, 4'd0, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqLookup, {32'd0, 32'd1}, 4'd3, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqTransition, {gbp_pkg::GenReset, 32'd2}, 4'd1, 4'd2,
                             1'b0, 1'b0, '0, '0, '0));
    table_rows.push_back(row(gbp_pkg::ReqTransition, {gbp_pkg::GenReset, 32'd2}, 4'd2, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd62));
    table_rows.push_back(row(gbp_pkg::ReqRelease, {gbp_pkg::GenReset, 32'd1}, 4'd3, 4'd0,
                             1'b0, 1'b0, '0, '0, '0));
    table_rows.push_back(row(gbp_pkg::ReqRelease, {gbp_pkg::GenReset, 32'd1}, 4'd3, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd63));
    table_rows.push_back(row(3'd6, {gbp_pkg::GenReset, 32'd2}, 4'd2, 4'd1,
                             1'b1, 1'b1, '0, '0, 7'd63));
    table_rows.push_back(row(3'd7, '1, 4'hF, 4'hF,
                             1'b1, 1'b1, '0, '0, 7'd63));
    table_rows.push_back(row(gbp_pkg::ReqAcquire, 64'd0, 4'd0, 4'd2,
                             1'b0, 1'b0, '0, '0, '0));
    table_rows.push_back(row(gbp_pkg::ReqRevoke, 64'd0, 4'd0, 4'd0,
                             1'b1, 1'b0, '0, '0, 7'd0));
    table_rows.push_back(row(gbp_pkg::ReqRevoke, 64'd0, 4'd0, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd0));
    table_rows.push_back(row(gbp_pkg::ReqAcquire, 64'd0, 4'd0, 4'd1,
                             1'b1, 1'b1, '0, '0, 7'd0));
    table_rows.push_back(row(gbp_pkg::ReqRelease, {32'h0001_0001, 32'd2}, 4'd0, 4'd0,
                             1'b1, 1'b1, '0, '0, 7'd0));
    table_rows.push_back(row(gbp_pkg::ReqRestart, 64'd0, 4'd0, 4'd0,
                             1'b1, 1'b0, '0, '0, 7'd64));
    table_rows.push_back(row(gbp_pkg::ReqLookup, '1, 4'hF, 4'hF,
                             1'b1, 1'b1, '0, '0, 7'd64));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (table_rows[i]) send_req(table_rows[i].req, table_rows[i].typed, table_rows[i].rsp);

    // extremes first; a count of 1 with the top generation exercises the wrap
    ph_count = '{7'd64, 7'd1, 7'd0, 7'd100, 7'd5, 7'd127, 7'd17};
    ph_gen = '{gbp_pkg::GenReset, 32'hFFFF_FFFF, 32'd0, $urandom(), 32'hFFFF_FFFE, 32'd1,
               $urandom()};
    sent = 0;
    for (int ph = 0; ph < 7; ph++) begin
      if (ph != 0) begin
        drain();
        cfg_write(gbp_pkg::CfgBufferCount, {25'($urandom()), ph_count[ph]});
        cfg_write(gbp_pkg::CfgGenerationBase, ph_gen[ph]);
        cfg_ch.valid <= 1'b0;
        send_req(pool_req_t'{kind: gbp_pkg::ReqRestart, handle: 64'd0, exp_st: 4'd0,
                             new_st: 4'd0}, 1'b0, '0);
      end
      for (int n = 0; n < 120; n++) begin
        if (sent < 280) begin
          send_idle_pct = 8;
          recv_idle_pct = 87;
        end else if (sent < 560) begin
          send_idle_pct = 87;
          recv_idle_pct = 8;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        r = random_req();
        send_req(r, 1'b0, '0);
        sent++;
      end
    end

    drain();
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
